// ===== hdl/dq_pkg.sv =====
// dq_pkg: shared constants, command and status codes, interface structs
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = ADDR_W + 1;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 11;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FRONT      = 3'd4,
    CMD_BACK       = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } res_info_t;

endpackage

// ===== hdl/dq_ram.sv =====
// dq_ram: single-port synchronous ram, registered read data
`timescale 1ns / 1ps

module dq_ram #(
  parameter int DEPTH_P = 1024,
  parameter int WIDTH_P = 64
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] addr,
  input  logic [WIDTH_P-1:0]         wdata,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/dq_ctrl.sv =====
// dq_ctrl: command decode, head pointer and fill count, ram request
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        command,
  output dq_pkg::mem_req_t  mem_req,
  output dq_pkg::res_info_t info
);

  logic [dq_pkg::ADDR_W-1:0] head, head_next;
  logic [dq_pkg::CNT_W-1:0]  fill, fill_next;
  logic [dq_pkg::ADDR_W-1:0] head_dec, head_inc, tail_slot, back_slot;
  logic [dq_pkg::SUM_W-1:0]  tail_sum, back_sum;
  logic                      full, empty;
  dq_pkg::status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (accept) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  assign full  = (fill == dq_pkg::DEPTH_C);
  assign empty = (fill == '0);

  assign head_dec = (head == '0) ? dq_pkg::LAST_ADDR : head - 1'b1;
  assign head_inc = (head == dq_pkg::LAST_ADDR) ? '0 : head + 1'b1;

  // head + fill and head + fill - 1, each below twice the depth
  assign tail_sum  = dq_pkg::SUM_W'(head) + dq_pkg::SUM_W'(fill);
  assign back_sum  = tail_sum - 1'b1;
  assign tail_slot = (tail_sum >= dq_pkg::DEPTH_S) ?
                     dq_pkg::ADDR_W'(tail_sum - dq_pkg::DEPTH_S) : dq_pkg::ADDR_W'(tail_sum);
  assign back_slot = (back_sum >= dq_pkg::DEPTH_S) ?
                     dq_pkg::ADDR_W'(back_sum - dq_pkg::DEPTH_S) : dq_pkg::ADDR_W'(back_sum);

  always_comb begin
    head_next   = head;
    fill_next   = fill;
    status      = dq_pkg::ST_OK;
    mem_req.en   = 1'b0;
    mem_req.we   = 1'b0;
    mem_req.addr = head;
    unique case (dq_pkg::cmd_t'(command))
      dq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          head_next    = head_dec;
          fill_next    = fill + 1'b1;
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = head_dec;
        end
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          fill_next    = fill + 1'b1;
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = tail_slot;
        end
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          status     = dq_pkg::ST_VALUE;
          mem_req.en = 1'b1;
          if (dq_pkg::cmd_t'(command) == dq_pkg::CMD_POP_FRONT) begin
            head_next = head_inc;
            fill_next = fill - 1'b1;
          end
        end
      end
      dq_pkg::CMD_POP_BACK, dq_pkg::CMD_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          status       = dq_pkg::ST_VALUE;
          mem_req.en   = 1'b1;
          mem_req.addr = back_slot;
          if (dq_pkg::cmd_t'(command) == dq_pkg::CMD_POP_BACK) begin
            fill_next = fill - 1'b1;
          end
        end
      end
      dq_pkg::CMD_SIZE: begin
        status = dq_pkg::ST_OK;
      end
      dq_pkg::CMD_CLEAR: begin
        head_next = '0;
        fill_next = '0;
      end
      default: begin
        status = dq_pkg::ST_OK;
      end
    endcase
    mem_req.en  = mem_req.en & accept;
    info.status = status;
    info.count  = dq_pkg::COUNT_W'(fill_next);
  end

endmodule

// ===== hdl/double_ended_queue.sv =====
// double_ended_queue: top level, ring store, read stage and result register
//
//   channel | beat                     | handshake
//   cmd     | command, value           | cmd_valid / cmd_ready
//   res     | status, data, count      | res_valid / res_ready
//
// one command per cycle while cmd_ready is high; a result passes the read stage, then the result register
// the ram read and the result register are each registered, pointer and count update at once
// rst clears head, count and the valid flags; the store itself is never cleared
// a stalled result holds the read stage, which then holds cmd_ready low
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic [2:0]                 command,
  input  logic signed [63:0]         value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [1:0]                 status,
  output logic signed [63:0]         data,
  output logic [10:0]                count
);

  dq_pkg::mem_req_t          mem_req;
  dq_pkg::res_info_t         info;
  dq_pkg::res_info_t         s1_info;
  logic                      s1_valid;
  logic                      s1_move;
  logic                      accept;
  logic [dq_pkg::WORD_W-1:0] rdata;

  assign s1_move   = !res_valid || res_ready;
  assign cmd_ready = !s1_valid || s1_move;
  assign accept    = cmd_valid && cmd_ready;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .mem_req (mem_req),
    .info    (info)
  );

  dq_ram #(
    .DEPTH_P (dq_pkg::DEPTH),
    .WIDTH_P (dq_pkg::WORD_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (value),
    .rdata (rdata)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      status <= s1_info.status;
      count  <= s1_info.count;
      data   <= (s1_info.status == dq_pkg::ST_VALUE) ? rdata : '0;
    end
  end

endmodule

// ===== hdl/dq_checker.sv =====
// dq_checker: port-level assertions for double_ended_queue, with bind
`timescale 1ns / 1ps

module dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  status,
  input logic [63:0] data,
  input logic [10:0] count
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(data) && $stable(count))
    else $error("result beat changed while stalled");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != dq_pkg::ST_VALUE) |-> data == '0)
    else $error("data not zero without a value");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == dq_pkg::ST_EMPTY) |-> count == '0)
    else $error("empty reported with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == dq_pkg::ST_FULL) |-> count == dq_pkg::COUNT_W'(dq_pkg::DEPTH))
    else $error("full reported below depth");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .status    (status),
  .data      (data),
  .count     (count)
);

// ===== tb/tb_double_ended_queue.sv =====
// tb_double_ended_queue: self-checking testbench with a deque predictor and result scoreboard
`timescale 1ns / 1ps

module tb_double_ended_queue;

  typedef struct {
    dq_pkg::status_t                   status;
    logic signed [dq_pkg::WORD_W-1:0]  data;
    logic [dq_pkg::COUNT_W-1:0]        count;
  } deque_result_t;

  typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK} mix_t;

  class deque_scoreboard;
    logic signed [dq_pkg::WORD_W-1:0] ring [dq_pkg::DEPTH];
    int                               head;
    int                               fill;
    deque_result_t                    expected_results[$];
    int                               errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_command(dq_pkg::cmd_t c, logic signed [dq_pkg::WORD_W-1:0] v);
      deque_result_t r;
      int            tail;
      r.status = dq_pkg::ST_OK;
      r.data   = '0;
      tail     = (head + fill + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
      case (c)
        dq_pkg::CMD_PUSH_FRONT: begin
          if (fill >= dq_pkg::DEPTH) begin
            r.status = dq_pkg::ST_FULL;
          end else begin
            head       = (head + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            ring[head] = v;
            fill++;
          end
        end
        dq_pkg::CMD_PUSH_BACK: begin
          if (fill >= dq_pkg::DEPTH) begin
            r.status = dq_pkg::ST_FULL;
          end else begin
            ring[(head + fill) % dq_pkg::DEPTH] = v;
            fill++;
          end
        end
        dq_pkg::CMD_POP_FRONT: begin
          if (fill == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            r.status = dq_pkg::ST_VALUE;
            r.data   = ring[head];
            head     = (head + 1) % dq_pkg::DEPTH;
            fill--;
          end
        end
        dq_pkg::CMD_POP_BACK: begin
          if (fill == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            r.status = dq_pkg::ST_VALUE;
            r.data   = ring[tail];
            fill--;
          end
        end
        dq_pkg::CMD_FRONT: begin
          if (fill == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            r.status = dq_pkg::ST_VALUE;
            r.data   = ring[head];
          end
        end
        dq_pkg::CMD_BACK: begin
          if (fill == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            r.status = dq_pkg::ST_VALUE;
            r.data   = ring[tail];
          end
        end
        dq_pkg::CMD_SIZE: begin
        end
        default: begin
          fill = 0;
          head = 0;
        end
      endcase
      r.count = dq_pkg::COUNT_W'(fill);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_result(logic [1:0] s, logic signed [dq_pkg::WORD_W-1:0] d,
                               logic [dq_pkg::COUNT_W-1:0] n);
      deque_result_t r;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d data %0d count %0d", s, d, n);
        errors++;
        return;
      end
      r = expected_results[0];
      expected_results.delete(0);
      if (s !== r.status) begin
        $error("status expected %0d actual %0d", r.status, s);
        errors++;
      end
      if (d !== r.data) begin
        $error("data expected %0d actual %0d", r.data, d);
        errors++;
      end
      if (n !== r.count) begin
        $error("count expected %0d actual %0d", r.count, n);
        errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               cmd_valid;
  logic                               cmd_ready;
  logic [2:0]                         command;
  logic signed [dq_pkg::WORD_W-1:0]   value;
  logic                               res_valid;
  logic                               res_ready;
  logic [1:0]                         status;
  logic signed [dq_pkg::WORD_W-1:0]   data;
  logic [dq_pkg::COUNT_W-1:0]         count;

  deque_scoreboard sb = new();
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  int              rx_hold     = 0;

  double_ended_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status    (status),
    .data      (data),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: sample at the edge, then pick next ready
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (res_valid && res_ready) sb.check_result(status, data, count);
        if (rx_hold > 0) begin
          rx_hold--;
          res_ready <= 1'b0;
        end else begin
          res_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
      end
    end
  end

  task automatic send_beat(input dq_pkg::cmd_t c, input logic signed [dq_pkg::WORD_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= c;
    value     <= v;
    do @(posedge clk); while (!cmd_ready);
    sb.note_command(c, v);
  endtask

  function automatic logic signed [dq_pkg::WORD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b0, {(dq_pkg::WORD_W-1){1'b1}}};
      1:       return {1'b1, {(dq_pkg::WORD_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic dq_pkg::cmd_t pick_command(mix_t mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MIX_GROW: begin
        if (roll < 80) return roll[0] ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
        return dq_pkg::cmd_t'($urandom_range(dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_SIZE));
      end
      MIX_SHRINK: begin
        if (roll < 65) return roll[0] ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT;
        if (roll < 97) begin
          return dq_pkg::cmd_t'($urandom_range(dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_SIZE));
        end
        return dq_pkg::CMD_CLEAR;
      end
      default: begin
        if (roll < 97) begin
          return dq_pkg::cmd_t'($urandom_range(dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_SIZE));
        end
        return dq_pkg::CMD_CLEAR;
      end
    endcase
  endfunction

  task automatic run_random(input int n);
    mix_t mode;
    int   run_left;
    run_left = 0;
    mode     = MIX_BALANCED;
    repeat (n) begin
      if (run_left == 0) begin
        mode     = mix_t'($urandom_range(2));
        run_left = $urandom_range(10, 50);
      end
      run_left--;
      send_beat(pick_command(mode), pick_value());
    end
  endtask

  initial begin
    int unsigned waited;
    waited    = 0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    command   <= dq_pkg::CMD_SIZE;
    value     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty queue, extremes, front wrap of the head, clear
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    send_beat(dq_pkg::CMD_SIZE, pick_value());
    send_beat(dq_pkg::CMD_POP_FRONT, pick_value());
    send_beat(dq_pkg::CMD_POP_BACK, pick_value());
    send_beat(dq_pkg::CMD_FRONT, pick_value());
    send_beat(dq_pkg::CMD_BACK, pick_value());
    send_beat(dq_pkg::CMD_PUSH_FRONT, {1'b0, {(dq_pkg::WORD_W-1){1'b1}}});
    send_beat(dq_pkg::CMD_PUSH_BACK, {1'b1, {(dq_pkg::WORD_W-1){1'b0}}});
    send_beat(dq_pkg::CMD_FRONT, '0);
    send_beat(dq_pkg::CMD_BACK, '1);
    send_beat(dq_pkg::CMD_PUSH_FRONT, '0);
    send_beat(dq_pkg::CMD_PUSH_BACK, '1);
    send_beat(dq_pkg::CMD_SIZE, '0);
    send_beat(dq_pkg::CMD_POP_BACK, '0);
    send_beat(dq_pkg::CMD_POP_FRONT, '0);
    send_beat(dq_pkg::CMD_POP_FRONT, '0);
    send_beat(dq_pkg::CMD_POP_BACK, '0);
    send_beat(dq_pkg::CMD_POP_FRONT, '0);
    send_beat(dq_pkg::CMD_PUSH_BACK, {(dq_pkg::WORD_W/2){2'b01}});
    send_beat(dq_pkg::CMD_PUSH_FRONT, {(dq_pkg::WORD_W/2){2'b10}});
    send_beat(dq_pkg::CMD_CLEAR, '1);
    send_beat(dq_pkg::CMD_FRONT, '0);
    send_beat(dq_pkg::CMD_SIZE, '0);
    send_beat(dq_pkg::CMD_PUSH_BACK, 64'sd1);

    tx_idle_pct = 22;
    rx_idle_pct = 87;
    run_random(50);

    tx_idle_pct = 87;
    rx_idle_pct = 22;
    run_random(50);

    // no idling; a long result hold-off at the start, then the store fills to the top
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold     = 300;
    send_beat(dq_pkg::CMD_CLEAR, pick_value());
    repeat (dq_pkg::DEPTH) begin
      send_beat($urandom_range(1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT, pick_value());
    end
    repeat (4) begin
      send_beat($urandom_range(1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT, pick_value());
    end
    send_beat(dq_pkg::CMD_FRONT, pick_value());
    send_beat(dq_pkg::CMD_BACK, pick_value());
    send_beat(dq_pkg::CMD_SIZE, pick_value());
    send_beat(dq_pkg::CMD_POP_BACK, pick_value());
    send_beat(dq_pkg::CMD_PUSH_FRONT, pick_value());
    send_beat(dq_pkg::CMD_PUSH_BACK, pick_value());
    run_random(40);
    cmd_valid <= 1'b0;

    while (sb.pending() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() > 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/tb_double_ended_queue.sv
